FILE: design/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg: shared types and constants of the Paxos acceptor table
// Field widths, message and reply codes, and the command word that travels
// from the front end to the table engine.
// ----------------------------------------------------------------------------
package pat_pkg;

	localparam int SLOT_W      = 11;
	localparam int BALLOT_W    = 32;
	localparam int VALUE_W     = 64;
	localparam int ID_W        = 8;
	localparam int OP_W        = 2;
	localparam int KIND_W      = 2;
	// Index of the last replayed instance within one hole request (0 to 63, so up to 64 replays).
	localparam int REPLAY_W    = 6;
	localparam int QUEUE_DEPTH = 2;

	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] REG_ACCEPTOR_NUMBER = '0;
	localparam logic [ID_W-1:0]    ACCEPTOR_NUMBER_RESET = 8'd1;

	typedef enum logic [OP_W-1:0] {
		OP_PREPARE = 2'd0,
		OP_ACCEPT  = 2'd1,
		OP_HOLE    = 2'd2,
		OP_OTHER   = 2'd3
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		REPLY_PROMISE  = 2'd0,
		REPLY_NACK     = 2'd1,
		REPLY_ACCEPTED = 2'd2,
		REPLY_VALUE    = 2'd3
	} reply_kind_t;

	typedef enum logic [1:0] {
		CMD_PREPARE = 2'd0,
		CMD_ACCEPT  = 2'd1,
		CMD_HOLE    = 2'd2
	} cmd_kind_t;

	// For a hole request, slot holds the first instance of the range.
	typedef struct packed {
		cmd_kind_t             kind;
		logic [SLOT_W-1:0]     slot;
		logic [BALLOT_W-1:0]   ballot;
		logic [VALUE_W-1:0]    value;
		logic [REPLAY_W-1:0]   last_idx;
	} cmd_t;

endpackage

FILE: design/pat_request_if.sv
// ----------------------------------------------------------------------------
// pat_request_if: incoming message channel
// Valid/ready channel that carries one acceptor message per word.
// ----------------------------------------------------------------------------
interface pat_request_if
	import pat_pkg::*;
();

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [SLOT_W-1:0]   slot;
	logic [BALLOT_W-1:0] proposal_ballot;
	logic [VALUE_W-1:0]  proposal_value;
	logic [SLOT_W-1:0]   range_low;
	logic [SLOT_W-1:0]   range_high;

	modport source (
		output valid, operation, slot, proposal_ballot, proposal_value,
		       range_low, range_high,
		input  ready
	);

	modport sink (
		input  valid, operation, slot, proposal_ballot, proposal_value,
		       range_low, range_high,
		output ready
	);

endinterface

FILE: design/pat_reply_if.sv
// ----------------------------------------------------------------------------
// pat_reply_if: outgoing reply channel
// Valid/ready channel that carries one reply or replayed value per word.
// ----------------------------------------------------------------------------
interface pat_reply_if
	import pat_pkg::*;
();

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   reply_kind;
	logic [ID_W-1:0]     sender;
	logic [SLOT_W-1:0]   reply_slot;
	logic [BALLOT_W-1:0] reply_ballot;
	logic [BALLOT_W-1:0] reply_value_ballot;
	logic [VALUE_W-1:0]  reply_value;
	logic                last;

	modport source (
		output valid, reply_kind, sender, reply_slot, reply_ballot,
		       reply_value_ballot, reply_value, last,
		input  ready
	);

	modport sink (
		input  valid, reply_kind, sender, reply_slot, reply_ballot,
		       reply_value_ballot, reply_value, last,
		output ready
	);

endinterface

FILE: design/pat_front.sv
// ----------------------------------------------------------------------------
// pat_front: message intake and classification
// Accepts request words, drops those that cause no reply, trims hole ranges
// to the table and the replay limit, and pushes commands into the queue.
// ----------------------------------------------------------------------------
module pat_front
	import pat_pkg::*;
#(
	parameter int INSTANCES  = 2048,
	parameter int MAX_REPLAY = 64
) (
	pat_request_if.sink request,
	input  logic        queue_full,
	input  logic        clearing,
	output logic        push,
	output cmd_t        push_cmd
);

	op_t               op;
	logic              slot_ok;
	logic              high_ok;
	logic              range_empty;
	logic              keep;
	logic [SLOT_W-1:0] high_cut;
	logic [SLOT_W:0]   span;

	always_comb begin
		op          = op_t'(request.operation);
		slot_ok     = 32'(request.slot) < INSTANCES;
		high_ok     = 32'(request.range_high) < INSTANCES;
		high_cut    = high_ok ? request.range_high : SLOT_W'(INSTANCES - 1);
		range_empty = high_cut < request.range_low;
		span        = {1'b0, high_cut} - {1'b0, request.range_low};

		push_cmd          = '0;
		push_cmd.slot     = request.slot;
		push_cmd.ballot   = request.proposal_ballot;
		push_cmd.value    = request.proposal_value;
		keep              = 1'b0;

		case (op)
			OP_PREPARE: begin
				push_cmd.kind = CMD_PREPARE;
				keep          = slot_ok;
			end
			OP_ACCEPT: begin
				push_cmd.kind = CMD_ACCEPT;
				keep          = slot_ok;
			end
			OP_HOLE: begin
				push_cmd.kind = CMD_HOLE;
				push_cmd.slot = request.range_low;
				keep          = !range_empty;
				// Long ranges stop after the replay limit.
				if (span >= (SLOT_W + 1)'(MAX_REPLAY - 1)) begin
					push_cmd.last_idx = REPLAY_W'(MAX_REPLAY - 1);
				end else begin
					push_cmd.last_idx = span[REPLAY_W-1:0];
				end
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign request.ready = !queue_full && !clearing;
	assign push          = request.valid && request.ready && keep;

endmodule

FILE: design/pat_queue.sv
// ----------------------------------------------------------------------------
// pat_queue: command queue between front end and table engine
// Small FIFO of classified commands so that intake and table work stall
// independently of each other.
// ----------------------------------------------------------------------------
module pat_queue
	import pat_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int QAW = $clog2(QUEUE_DEPTH);

	cmd_t            entries_q [QUEUE_DEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [QAW:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QAW + 1)'(push) - (QAW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign full       = count_q == (QAW + 1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = entries_q[rd_ptr_q];

endmodule

FILE: design/pat_back.sv
// ----------------------------------------------------------------------------
// pat_back: table engine
// Owns the instance table memory. Runs the clearing pass after reset, then
// executes prepare, accept and hole commands and drives the reply register.
// ----------------------------------------------------------------------------
module pat_back
	import pat_pkg::*;
#(
	parameter int INSTANCES  = 2048,
	parameter int VALUE_BITS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [ID_W-1:0] acceptor_number,
	input  logic            head_valid,
	input  cmd_t            head_cmd,
	output logic            pop,
	output logic            clearing,
	pat_reply_if.source     reply
);

	localparam int AW      = $clog2(INSTANCES);
	localparam int ENTRY_W = 2 * BALLOT_W + VALUE_BITS;

	typedef enum logic {
		S_IDLE,
		S_USE
	} state_t;

	// Entry layout: promised ballot, accepted ballot, accepted value.
	logic [ENTRY_W-1:0]  store_q [INSTANCES];
	logic [ENTRY_W-1:0]  rdata_s1;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [SLOT_W-1:0]   ptr_q;
	logic [REPLAY_W-1:0] left_q;
	logic                clear_busy_q;
	logic [AW-1:0]       clear_addr_q;

	logic                out_valid_q;
	reply_kind_t         out_kind_q;
	logic [ID_W-1:0]     out_sender_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [BALLOT_W-1:0] out_ballot_q;
	logic [BALLOT_W-1:0] out_vbal_q;
	logic [VALUE_W-1:0]  out_value_q;
	logic                out_last_q;

	logic                out_free;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [ENTRY_W-1:0]  mem_wdata;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	logic                start;
	logic                done;
	logic                step;
	logic                load;
	reply_kind_t         nxt_kind;
	logic [SLOT_W-1:0]   nxt_slot;
	logic [BALLOT_W-1:0] nxt_ballot;
	logic [BALLOT_W-1:0] nxt_vbal;
	logic [VALUE_W-1:0]  nxt_value;
	logic                nxt_last;
	logic [BALLOT_W-1:0] rd_promised;
	logic [BALLOT_W-1:0] rd_acc_ballot;
	logic [VALUE_BITS-1:0] rd_value;
	logic [VALUE_BITS-1:0] cmd_value;

	always_comb begin
		rd_promised   = rdata_s1[ENTRY_W-1 -: BALLOT_W];
		rd_acc_ballot = rdata_s1[VALUE_BITS +: BALLOT_W];
		rd_value      = rdata_s1[VALUE_BITS-1:0];
		cmd_value     = VALUE_BITS'(head_cmd.value);
		out_free      = !out_valid_q || reply.ready;

		mem_we     = 1'b0;
		mem_waddr  = clear_addr_q;
		mem_wdata  = '0;
		mem_re     = 1'b0;
		mem_raddr  = AW'(head_cmd.slot);
		pop        = 1'b0;
		start      = 1'b0;
		done       = 1'b0;
		step       = 1'b0;
		load       = 1'b0;
		nxt_kind   = REPLY_NACK;
		nxt_slot   = ptr_q;
		nxt_ballot = '0;
		nxt_vbal   = '0;
		nxt_value  = '0;
		nxt_last   = 1'b1;

		if (clear_busy_q) begin
			mem_we = 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						case (head_cmd.kind)
							CMD_PREPARE, CMD_HOLE: begin
								mem_re = 1'b1;
								pop    = 1'b1;
								start  = 1'b1;
							end
							CMD_ACCEPT: begin
								// Accept needs no read: it overwrites the whole entry.
								if (out_free) begin
									mem_we     = 1'b1;
									mem_waddr  = AW'(head_cmd.slot);
									mem_wdata  = {head_cmd.ballot, head_cmd.ballot, cmd_value};
									pop        = 1'b1;
									load       = 1'b1;
									nxt_kind   = REPLY_ACCEPTED;
									nxt_slot   = head_cmd.slot;
									nxt_ballot = head_cmd.ballot;
									nxt_value  = VALUE_W'(cmd_value);
								end
							end
							default: begin
								pop = 1'b1;
							end
						endcase
					end
				end
				S_USE: begin
					if (out_free) begin
						load = 1'b1;
						if (cmd_q.kind == CMD_PREPARE) begin
							done     = 1'b1;
							nxt_slot = cmd_q.slot;
							if (cmd_q.ballot > rd_promised) begin
								mem_we     = 1'b1;
								mem_waddr  = AW'(cmd_q.slot);
								mem_wdata  = {cmd_q.ballot, rd_acc_ballot, rd_value};
								nxt_kind   = REPLY_PROMISE;
								nxt_ballot = cmd_q.ballot;
								nxt_vbal   = rd_acc_ballot;
								nxt_value  = VALUE_W'(rd_value);
							end else begin
								nxt_kind   = REPLY_NACK;
								nxt_ballot = rd_promised;
							end
						end else begin
							nxt_kind  = REPLY_VALUE;
							nxt_value = VALUE_W'(rd_value);
							nxt_last  = left_q == '0;
							if (left_q == '0) begin
								done = 1'b1;
							end else begin
								// Fetch the next instance while this one goes out.
								step      = 1'b1;
								mem_re    = 1'b1;
								mem_raddr = AW'(ptr_q + 1'b1);
							end
						end
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= store_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= '0;
			ptr_q        <= '0;
			left_q       <= '0;
			clear_busy_q <= 1'b1;
			clear_addr_q <= '0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= REPLY_PROMISE;
			out_sender_q <= '0;
			out_slot_q   <= '0;
			out_ballot_q <= '0;
			out_vbal_q   <= '0;
			out_value_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (clear_busy_q) begin
				clear_addr_q <= clear_addr_q + 1'b1;
				if (clear_addr_q == AW'(INSTANCES - 1)) begin
					clear_busy_q <= 1'b0;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_USE;
						cmd_q   <= head_cmd;
						ptr_q   <= head_cmd.slot;
						left_q  <= head_cmd.last_idx;
					end
				end
				S_USE: begin
					if (done) begin
						state_q <= S_IDLE;
					end else if (step) begin
						ptr_q  <= ptr_q + 1'b1;
						left_q <= left_q - 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (load) begin
				out_valid_q  <= 1'b1;
				out_kind_q   <= nxt_kind;
				out_sender_q <= acceptor_number;
				out_slot_q   <= nxt_slot;
				out_ballot_q <= nxt_ballot;
				out_vbal_q   <= nxt_vbal;
				out_value_q  <= nxt_value;
				out_last_q   <= nxt_last;
			end else if (reply.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign clearing                 = clear_busy_q;
	assign reply.valid              = out_valid_q;
	assign reply.reply_kind         = out_kind_q;
	assign reply.sender             = out_sender_q;
	assign reply.reply_slot         = out_slot_q;
	assign reply.reply_ballot       = out_ballot_q;
	assign reply.reply_value_ballot = out_vbal_q;
	assign reply.reply_value        = out_value_q;
	assign reply.last               = out_last_q;

endmodule

FILE: design/paxos_acceptor_table.sv
// Replies: a prepare is answered after a table read, then a compare and write; an
// accept loads its reply in the same cycle as its table write; a hole request reads its
// first instance, then fetches each next one while the previous value goes out.
// Throughput: one word a cycle into a 2-deep command queue while it has room and no
// clearing pass runs; the engine finishes each command before the next, all on one table port.
// Reset: after arst_n is released, a clearing pass zeroes the table for INSTANCES cycles,
// during which no request word is taken; configuration writes are accepted throughout.
// ----------------------------------------------------------------------------
// paxos_acceptor_table: Paxos acceptor over a table of consensus instances
// Front end classifies messages into a command queue; the table engine runs
// prepare, accept and hole replay against the instance table.
// ----------------------------------------------------------------------------
module paxos_acceptor_table
	import pat_pkg::*;
#(
	parameter int INSTANCES  = 2048,
	parameter int VALUE_BITS = 64,
	parameter int MAX_REPLAY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	pat_request_if.sink        request,
	pat_reply_if.source        reply
);

	logic [ID_W-1:0] acceptor_number_q;
	logic            queue_full;
	logic            clearing;
	logic            q_push;
	cmd_t            q_push_cmd;
	logic            q_pop;
	logic            q_valid;
	cmd_t            q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acceptor_number_q <= ACCEPTOR_NUMBER_RESET;
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_ACCEPTOR_NUMBER) begin
				acceptor_number_q <= pwdata[ID_W-1:0];
			end
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == REG_ACCEPTOR_NUMBER) ? PDATA_W'(acceptor_number_q) : '0;

	pat_front #(
		.INSTANCES  (INSTANCES),
		.MAX_REPLAY (MAX_REPLAY)
	) u_front (
		.request    (request),
		.queue_full (queue_full),
		.clearing   (clearing),
		.push       (q_push),
		.push_cmd   (q_push_cmd)
	);

	pat_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_push_cmd),
		.full       (queue_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_cmd   (q_head)
	);

	pat_back #(
		.INSTANCES  (INSTANCES),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.acceptor_number (acceptor_number_q),
		.head_valid      (q_valid),
		.head_cmd        (q_head),
		.pop             (q_pop),
		.clearing        (clearing),
		.reply           (reply)
	);

	// The engine only takes commands that are present in the queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("command popped from an empty queue");

	// Nothing enters or leaves while the table is being cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !request.ready && !reply.valid)
		else $error("traffic during the clearing pass");

	// Only a replayed value can be followed by more words of the same message.
	assert property (@(posedge clk) disable iff (!arst_n)
		reply.valid && reply.reply_kind != REPLY_VALUE |-> reply.last)
		else $error("single reply without last flag");

	// A queue push always lands in a queue with room.
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !queue_full)
		else $error("push into a full command queue");

endmodule

FILE: sim/tb_paxos_acceptor_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_paxos_acceptor_table: self-checking bench for the Paxos acceptor table
// A directed table of messages runs first, then phases of random prepare,
// accept, hole-request and other traffic aimed at a small pool of instances
// under several acceptor numbers. Every reply word is checked field by field.
// ----------------------------------------------------------------------------
module tb_paxos_acceptor_table;
	import pat_pkg::*;

	localparam int TABLE_DEPTH    = 2048;
	localparam int REPLAY_LIMIT   = 64;
	localparam int DRAIN_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASES         = 4;
	localparam int PHASE_ITEMS    = 86;
	localparam int POOL_SIZE      = 10;
	localparam int DIRECTED_ROWS  = 25;

	typedef struct packed {
		op_t                 op;
		logic [SLOT_W-1:0]   slot;
		logic [BALLOT_W-1:0] ballot;
		logic [VALUE_W-1:0]  value;
		logic [SLOT_W-1:0]   lo;
		logic [SLOT_W-1:0]   hi;
	} message_t;

	typedef struct packed {
		reply_kind_t         kind;
		logic [ID_W-1:0]     sender;
		logic [SLOT_W-1:0]   slot;
		logic [BALLOT_W-1:0] ballot;
		logic [BALLOT_W-1:0] vbal;
		logic [VALUE_W-1:0]  value;
		logic                last;
	} reply_t;

	typedef struct packed {
		message_t msg;
		logic     typed;
		reply_t   want;
	} plan_row_t;

	localparam reply_t NO_REPLY = '{REPLY_PROMISE, 8'd0, 11'd0, 32'd0, 32'd0, 64'd0, 1'b0};
	localparam logic [VALUE_W-1:0] ONES = {VALUE_W{1'b1}};
	localparam logic [VALUE_W-1:0] EDGE_VALUE = 64'h8000_0000_0000_0001;

	localparam plan_row_t PLAN [DIRECTED_ROWS] = '{
		'{'{OP_PREPARE, 11'd0, 32'd0, 64'd0, 11'd0, 11'd0}, 1'b1,
			'{REPLY_NACK, 8'd1, 11'd0, 32'd0, 32'd0, 64'd0, 1'b1}},
		'{'{OP_PREPARE, 11'd0, 32'd5, 64'd0, 11'd0, 11'd0}, 1'b1,
			'{REPLY_PROMISE, 8'd1, 11'd0, 32'd5, 32'd0, 64'd0, 1'b1}},
		'{'{OP_PREPARE, 11'd0, 32'd5, 64'd0, 11'd0, 11'd0}, 1'b1,
			'{REPLY_NACK, 8'd1, 11'd0, 32'd5, 32'd0, 64'd0, 1'b1}},
		'{'{OP_PREPARE, 11'd0, 32'd4, 64'd0, 11'd0, 11'd0}, 1'b1,
			'{REPLY_NACK, 8'd1, 11'd0, 32'd5, 32'd0, 64'd0, 1'b1}},
		'{'{OP_ACCEPT, 11'd0, 32'd3, ONES, 11'd0, 11'd0}, 1'b1,
			'{REPLY_ACCEPTED, 8'd1, 11'd0, 32'd3, 32'd0, ONES, 1'b1}},
		'{'{OP_PREPARE, 11'd0, 32'd4, 64'd0, 11'd0, 11'd0}, 1'b1,
			'{REPLY_PROMISE, 8'd1, 11'd0, 32'd4, 32'd3, ONES, 1'b1}},
		'{'{OP_PREPARE, 11'd2047, 32'hFFFF_FFFF, 64'd0, 11'd0, 11'd0}, 1'b1,
			'{REPLY_PROMISE, 8'd1, 11'd2047, 32'hFFFF_FFFF, 32'd0, 64'd0, 1'b1}},
		'{'{OP_PREPARE, 11'd2047, 32'hFFFF_FFFF, 64'd0, 11'd0, 11'd0}, 1'b1,
			'{REPLY_NACK, 8'd1, 11'd2047, 32'hFFFF_FFFF, 32'd0, 64'd0, 1'b1}},
		'{'{OP_ACCEPT, 11'd2047, 32'hFFFF_FFFF, 64'd0, 11'd0, 11'd0}, 1'b1,
			'{REPLY_ACCEPTED, 8'd1, 11'd2047, 32'hFFFF_FFFF, 32'd0, 64'd0, 1'b1}},
		'{'{OP_ACCEPT, 11'd2047, 32'd0, EDGE_VALUE, 11'd0, 11'd0}, 1'b1,
			'{REPLY_ACCEPTED, 8'd1, 11'd2047, 32'd0, 32'd0, EDGE_VALUE, 1'b1}},
		'{'{OP_PREPARE, 11'd2047, 32'd1, 64'd0, 11'd0, 11'd0}, 1'b1,
			'{REPLY_PROMISE, 8'd1, 11'd2047, 32'd1, 32'd0, EDGE_VALUE, 1'b1}},
		'{'{OP_ACCEPT, 11'h555, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 11'd0, 11'd0}, 1'b1,
			'{REPLY_ACCEPTED, 8'd1, 11'h555, 32'hAAAA_AAAA, 32'd0,
				64'h5555_5555_5555_5555, 1'b1}},
		'{'{OP_ACCEPT, 11'h2AA, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 11'd0, 11'd0}, 1'b1,
			'{REPLY_ACCEPTED, 8'd1, 11'h2AA, 32'h5555_5555, 32'd0,
				64'hAAAA_AAAA_AAAA_AAAA, 1'b1}},
		'{'{OP_OTHER, 11'h7FF, 32'hFFFF_FFFF, ONES, 11'h7FF, 11'h7FF}, 1'b0, NO_REPLY},
		'{'{OP_OTHER, 11'd0, 32'd0, 64'd0, 11'd0, 11'd0}, 1'b0, NO_REPLY},
		'{'{OP_HOLE, 11'd0, 32'd0, 64'd0, 11'd5, 11'd4}, 1'b0, NO_REPLY},
		'{'{OP_HOLE, 11'd0, 32'd0, 64'd0, 11'd2047, 11'd0}, 1'b0, NO_REPLY},
		'{'{OP_HOLE, 11'd0, 32'd0, 64'd0, 11'd0, 11'd0}, 1'b1,
			'{REPLY_VALUE, 8'd1, 11'd0, 32'd0, 32'd0, ONES, 1'b1}},
		'{'{OP_HOLE, 11'd0, 32'd0, 64'd0, 11'd2047, 11'd2047}, 1'b1,
			'{REPLY_VALUE, 8'd1, 11'd2047, 32'd0, 32'd0, EDGE_VALUE, 1'b1}},
		'{'{OP_HOLE, 11'd0, 32'd0, 64'd0, 11'd0, 11'd2047}, 1'b0, NO_REPLY},
		'{'{OP_HOLE, 11'd0, 32'd0, 64'd0, 11'd1984, 11'd2047}, 1'b0, NO_REPLY},
		'{'{OP_HOLE, 11'd0, 32'd0, 64'd0, 11'd1300, 11'd1400}, 1'b0, NO_REPLY},
		'{'{OP_HOLE, 11'd0, 32'd0, 64'd0, 11'd680, 11'd690}, 1'b0, NO_REPLY},
		'{'{OP_PREPARE, 11'h555, 32'hAAAA_AAAB, 64'd0, 11'd0, 11'd0}, 1'b0, NO_REPLY},
		'{'{OP_PREPARE, 11'h555, 32'd1, 64'd0, 11'd0, 11'd0}, 1'b1,
			'{REPLY_NACK, 8'd1, 11'h555, 32'hAAAA_AAAB, 32'd0, 64'd0, 1'b1}}
	};

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	pat_request_if rq ();
	pat_reply_if   rp ();

	paxos_acceptor_table DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.request (rq),
		.reply   (rp)
	);

	// Shadow of the instance table and the acceptor number.
	bit                  entry_used      [TABLE_DEPTH];
	bit [BALLOT_W-1:0]   promised        [TABLE_DEPTH];
	bit [BALLOT_W-1:0]   accepted_ballot [TABLE_DEPTH];
	bit [VALUE_W-1:0]    accepted_value  [TABLE_DEPTH];
	logic [ID_W-1:0]     sender_id;

	reply_t              predicted[$];
	reply_t              awaited_replies[$];
	reply_t              head;
	logic [SLOT_W-1:0]   slot_pool [POOL_SIZE];
	int                  mismatches;
	int                  quiet_cycles;
	int                  rush_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Works out the reply words of one message and updates the shadow table.
	function automatic void acceptor_replies(input message_t m);
		int     count;
		reply_t r;
		predicted.delete();
		case (m.op)
			OP_PREPARE: begin
				if (!entry_used[m.slot]) begin
					entry_used[m.slot]      = 1'b1;
					promised[m.slot]        = '0;
					accepted_ballot[m.slot] = '0;
					accepted_value[m.slot]  = '0;
				end
				if (m.ballot > promised[m.slot]) begin
					promised[m.slot] = m.ballot;
					r = '{REPLY_PROMISE, sender_id, m.slot, m.ballot, accepted_ballot[m.slot],
						accepted_value[m.slot], 1'b1};
				end else begin
					r = '{REPLY_NACK, sender_id, m.slot, promised[m.slot], 32'd0, 64'd0, 1'b1};
				end
				predicted.push_back(r);
			end
			OP_ACCEPT: begin
				entry_used[m.slot]      = 1'b1;
				promised[m.slot]        = m.ballot;
				accepted_ballot[m.slot] = m.ballot;
				accepted_value[m.slot]  = m.value;
				r = '{REPLY_ACCEPTED, sender_id, m.slot, m.ballot, 32'd0, m.value, 1'b1};
				predicted.push_back(r);
			end
			OP_HOLE: begin
				if (m.hi >= m.lo) begin
					count = int'(m.hi) - int'(m.lo) + 1;
					if (count > REPLAY_LIMIT)
						count = REPLAY_LIMIT;
					for (int i = 0; i < count; i++) begin
						r = '{REPLY_VALUE, sender_id, SLOT_W'(int'(m.lo) + i), 32'd0, 32'd0,
							accepted_value[int'(m.lo) + i], (i == count - 1)};
						predicted.push_back(r);
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Idle gap before the next request word, with occasional back-to-back runs.
	function automatic int request_gap();
		if (rush_left > 0) begin
			rush_left--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0)
			rush_left = $urandom_range(15, 40);
		return idle_span();
	endfunction

	function automatic logic [SLOT_W-1:0] pick_slot();
		if ($urandom_range(0, 4) == 0)
			return SLOT_W'($urandom_range(0, TABLE_DEPTH - 1));
		return slot_pool[$urandom_range(0, POOL_SIZE - 1)];
	endfunction

	function automatic logic [BALLOT_W-1:0] pick_ballot();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return BALLOT_W'($urandom_range(0, 12));
		if (r == 6)
			return 32'hFFFF_FFFF - BALLOT_W'($urandom_range(0, 3));
		return $urandom;
	endfunction

	function automatic message_t random_message();
		message_t m;
		int       r;
		int       base;
		int       lo;
		int       hi;
		r       = $urandom_range(0, 99);
		m.op    = (r < 38) ? OP_PREPARE : (r < 66) ? OP_ACCEPT : (r < 88) ? OP_HOLE : OP_OTHER;
		m.slot  = pick_slot();
		m.ballot = pick_ballot();
		m.value = {$urandom, $urandom};
		m.lo    = SLOT_W'($urandom);
		m.hi    = SLOT_W'($urandom);
		if (m.op == OP_HOLE) begin
			base = int'(pick_slot());
			r    = $urandom_range(0, 99);
			if (r < 10) begin
				// Range given backwards, so nothing is replayed unless lo is clamped down to hi.
				lo = base + $urandom_range(1, 20);
				hi = base;
			end else if (r < 16) begin
				lo = base;
				hi = base + $urandom_range(64, 300);
			end else begin
				lo = base - $urandom_range(0, 3);
				hi = lo + $urandom_range(0, 6);
			end
			if (lo < 0)
				lo = 0;
			if (lo > TABLE_DEPTH - 1)
				lo = TABLE_DEPTH - 1;
			if (hi > TABLE_DEPTH - 1)
				hi = TABLE_DEPTH - 1;
			m.lo = SLOT_W'(lo);
			m.hi = SLOT_W'(hi);
		end
		return m;
	endfunction

	task automatic offer_message(input message_t m, input int gap);
		repeat (gap) begin
			@(negedge clk);
			rq.valid <= 1'b0;
		end
		@(negedge clk);
		rq.valid           <= 1'b1;
		rq.operation       <= m.op;
		rq.slot            <= m.slot;
		rq.proposal_ballot <= m.ballot;
		rq.proposal_value  <= m.value;
		rq.range_low       <= m.lo;
		rq.range_high      <= m.hi;
		do
			@(posedge clk);
		while (!rq.ready);
	endtask

	task automatic write_register(input logic [PADDR_W-1:0] addr,
		input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (addr == REG_ACCEPTOR_NUMBER)
			sender_id = data[ID_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Lets the block run dry: every awaited reply in, then a margin for
	// messages that produce no reply at all.
	task automatic settle();
		@(negedge clk);
		rq.valid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Reply sink with random back-pressure.
	initial begin
		int hold;
		rp.ready = 1'b0;
		forever begin
			hold = idle_span();
			repeat (hold) begin
				@(negedge clk);
				rp.ready <= 1'b0;
			end
			hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 6);
			repeat (hold) begin
				@(negedge clk);
				rp.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rp.valid && rp.ready) begin
			if (awaited_replies.size() == 0) begin
				$error("reply word with nothing awaited: kind %0d slot %0d",
					rp.reply_kind, rp.reply_slot);
				mismatches++;
			end else begin
				head = awaited_replies.pop_front();
				if (rp.reply_kind !== head.kind) begin
					$error("reply_kind: expected %0d, got %0d", head.kind, rp.reply_kind);
					mismatches++;
				end
				if (rp.sender !== head.sender) begin
					$error("sender: expected %0d, got %0d", head.sender, rp.sender);
					mismatches++;
				end
				if (rp.reply_slot !== head.slot) begin
					$error("reply_slot: expected %0d, got %0d", head.slot, rp.reply_slot);
					mismatches++;
				end
				if (rp.reply_ballot !== head.ballot) begin
					$error("reply_ballot: expected %h, got %h", head.ballot, rp.reply_ballot);
					mismatches++;
				end
				if (rp.reply_value_ballot !== head.vbal) begin
					$error("reply_value_ballot: expected %h, got %h", head.vbal,
						rp.reply_value_ballot);
					mismatches++;
				end
				if (rp.reply_value !== head.value) begin
					$error("reply_value: expected %h, got %h", head.value, rp.reply_value);
					mismatches++;
				end
				if (rp.last !== head.last) begin
					$error("last: expected %0d, got %0d", head.last, rp.last);
					mismatches++;
				end
			end
		end
	end

	// Ends a hung run: counts cycles in which no word moves on either channel.
	always @(posedge clk) begin
		if (!arst_n || (rq.valid && rq.ready) || (rp.valid && rp.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("paxos_acceptor_table: mismatch");
				$finish;
			end
		end
	end

	initial begin
		logic [ID_W-1:0] phase_id;
		message_t        m;
		int              counted;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		rq.valid           = 1'b0;
		rq.operation       = '0;
		rq.slot            = '0;
		rq.proposal_ballot = '0;
		rq.proposal_value  = '0;
		rq.range_low       = '0;
		rq.range_high      = '0;
		sender_id          = ACCEPTOR_NUMBER_RESET;
		mismatches         = 0;
		quiet_cycles       = 0;
		rush_left          = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The table clears itself after reset; offers simply wait for ready.
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			offer_message(PLAN[i].msg, request_gap());
			acceptor_replies(PLAN[i].msg);
			if (PLAN[i].typed)
				awaited_replies.push_back(PLAN[i].want);
			else
				foreach (predicted[k])
					awaited_replies.push_back(predicted[k]);
		end
		settle();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       phase_id = 8'd255;
				2:       phase_id = 8'd1;
				default: phase_id = ID_W'($urandom_range(2, 254));
			endcase
			write_register(REG_ACCEPTOR_NUMBER, {(PDATA_W - ID_W)'($urandom), phase_id});
			slot_pool[0] = '0;
			slot_pool[1] = SLOT_W'(TABLE_DEPTH - 1);
			for (int i = 2; i < POOL_SIZE; i++)
				slot_pool[i] = SLOT_W'($urandom_range(0, TABLE_DEPTH - 1));
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				m = random_message();
				offer_message(m, request_gap());
				acceptor_replies(m);
				foreach (predicted[k])
					awaited_replies.push_back(predicted[k]);
				counted++;
			end
			settle();
		end

		if (awaited_replies.size() != 0) begin
			$error("%0d reply words never arrived", awaited_replies.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("paxos_acceptor_table: match");
		else
			$display("paxos_acceptor_table: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
design/pat_pkg.sv
design/pat_request_if.sv
design/pat_reply_if.sv
design/pat_front.sv
design/pat_queue.sv
design/pat_back.sv
design/paxos_acceptor_table.sv
sim/tb_paxos_acceptor_table.sv
